// File: src/hctd_pkg.sv
package hctd_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   localparam logic [1:0] REG_DIVIDER = 2'd0;
   localparam logic [1:0] REG_COUNTER = 2'd1;
   localparam logic [1:0] REG_RELOAD  = 2'd2;
   localparam logic [1:0] REG_CONTROL = 2'd3;

   // control bits 1:0 pick the prescaler period
   localparam logic [1:0] PERIOD_1024 = 2'd0;
   localparam logic [1:0] PERIOD_16   = 2'd1;
   localparam logic [1:0] PERIOD_64   = 2'd2;
   localparam logic [1:0] PERIOD_256  = 2'd3;

   localparam int CTRL_ENABLE_BIT = 2;
   localparam int PRESCALE_W      = 10;
   localparam int CYCLES_W        = 9;

   typedef struct packed {
      cmd_type     command;
      logic [1:0]  register_select;
      logic [7:0]  write_data;
      logic [7:0]  cycle_count;
   } item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        timer_interrupt;
   } result_type;

endpackage

// File: src/handheld_console_timer_divider.sv
// Flow: an accepted item is held in the input register; when it advances it is
// applied to the timer state and its result is registered, which raises rsp_valid.
// Throughput: one item per cycle while rsp_stall is low.
// Reset (synchronous, active high) clears the timer state registers, the
// double-speed bit and both pipeline valid flags.
module handheld_console_timer_divider #(
   parameter int DIVIDER_PERIOD = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [1:0]  req_register_select,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_cycle_count,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_timer_interrupt,

   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic                  in_valid_ff, in_valid_in;
   hctd_pkg::item_type    item_ff;
   logic                  out_valid_ff, out_valid_in;
   hctd_pkg::result_type  result_ff;
   hctd_pkg::result_type  core_result;
   logic                  double_speed_ff;
   logic                  advance;
   logic                  accept;

   // item moves into the result register when that register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         double_speed_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            double_speed_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.command         <= hctd_pkg::cmd_type'(req_command);
         item_ff.register_select <= req_register_select;
         item_ff.write_data      <= req_write_data;
         item_ff.cycle_count     <= req_cycle_count;
      end
      if (advance) begin
         result_ff <= core_result;
      end
   end

   hctd_core #(
      .DIVIDER_PERIOD(DIVIDER_PERIOD)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .double_speed (double_speed_ff),
      .item         (item_ff),
      .result       (core_result)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_read_data       = result_ff.read_data;
   assign rsp_timer_interrupt = result_ff.timer_interrupt;

endmodule

// File: src/hctd_core.sv
module hctd_core #(
   parameter int DIVIDER_PERIOD = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  double_speed,
   input  hctd_pkg::item_type    item,
   output hctd_pkg::result_type  result
);

   localparam int ACC_W = $clog2(DIVIDER_PERIOD);
   localparam int SUM_W = ((ACC_W > hctd_pkg::CYCLES_W) ? ACC_W : hctd_pkg::CYCLES_W) + 1;
   localparam int PRE_SUM_W = hctd_pkg::PRESCALE_W + 1;

   logic [7:0]                        divider_ff, divider_in;
   logic [ACC_W-1:0]                  div_acc_ff, div_acc_in;
   logic [7:0]                        timer_ff, timer_in;
   logic [7:0]                        reload_ff, reload_in;
   logic [7:0]                        control_ff, control_in;
   logic [hctd_pkg::PRESCALE_W-1:0]   prescale_ff, prescale_in;

   logic [hctd_pkg::CYCLES_W-1:0]     cycles;
   logic [SUM_W-1:0]                  div_sum;
   logic [PRE_SUM_W-1:0]              pre_sum;
   logic [6:0]                        passed;
   logic [hctd_pkg::PRESCALE_W-1:0]   pre_rem;
   logic [8:0]                        timer_sum;
   logic                              tick_irq;

   always_comb begin
      cycles  = double_speed ? {item.cycle_count, 1'b0} : {1'b0, item.cycle_count};
      div_sum = SUM_W'(div_acc_ff) + SUM_W'(cycles);
      pre_sum = PRE_SUM_W'(prescale_ff) + PRE_SUM_W'(cycles);

      unique case (control_ff[1:0])
         hctd_pkg::PERIOD_1024: begin
            passed  = 7'(pre_sum >> 10);
            pre_rem = 10'(pre_sum & 11'h3FF);
         end
         hctd_pkg::PERIOD_16: begin
            passed  = 7'(pre_sum >> 4);
            pre_rem = 10'(pre_sum & 11'h00F);
         end
         hctd_pkg::PERIOD_64: begin
            passed  = 7'(pre_sum >> 6);
            pre_rem = 10'(pre_sum & 11'h03F);
         end
         default: begin
            passed  = 7'(pre_sum >> 8);
            pre_rem = 10'(pre_sum & 11'h0FF);
         end
      endcase

      // passed is zero unless a period completed, so no extra test needed
      timer_sum = {1'b0, timer_ff} + 9'(passed);
   end

   always_comb begin
      divider_in  = divider_ff;
      div_acc_in  = div_acc_ff;
      timer_in    = timer_ff;
      reload_in   = reload_ff;
      control_in  = control_ff;
      prescale_in = prescale_ff;
      tick_irq    = 1'b0;
      result      = '0;

      unique case (item.command)
         hctd_pkg::CMD_TICK: begin
            divider_in = divider_ff + 8'(div_sum >> ACC_W);
            div_acc_in = div_sum[ACC_W-1:0];
            if (control_ff[hctd_pkg::CTRL_ENABLE_BIT]) begin
               prescale_in = pre_rem;
               if (timer_sum[8]) begin
                  timer_in = reload_ff;
                  tick_irq = 1'b1;
               end else begin
                  timer_in = timer_sum[7:0];
               end
            end
            result.timer_interrupt = tick_irq;
         end
         hctd_pkg::CMD_READ: begin
            unique case (item.register_select)
               hctd_pkg::REG_DIVIDER: result.read_data = divider_ff;
               hctd_pkg::REG_COUNTER: result.read_data = timer_ff;
               hctd_pkg::REG_RELOAD:  result.read_data = reload_ff;
               default:               result.read_data = control_ff;
            endcase
         end
         hctd_pkg::CMD_WRITE: begin
            unique case (item.register_select)
               hctd_pkg::REG_DIVIDER: begin
                  // written byte is ignored, divider just clears
                  divider_in = '0;
                  div_acc_in = '0;
               end
               hctd_pkg::REG_COUNTER: timer_in   = item.write_data;
               hctd_pkg::REG_RELOAD:  reload_in  = item.write_data;
               default:               control_in = item.write_data;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff  <= '0;
         div_acc_ff  <= '0;
         timer_ff    <= '0;
         reload_ff   <= '0;
         control_ff  <= '0;
         prescale_ff <= '0;
      end else if (fire) begin
         divider_ff  <= divider_in;
         div_acc_ff  <= div_acc_in;
         timer_ff    <= timer_in;
         reload_ff   <= reload_in;
         control_ff  <= control_in;
         prescale_ff <= prescale_in;
      end
   end

endmodule
